### rtl/obb_pkg.sv
// Package for the oriented-box overlap pipeline.
// Field width and count, axis count and default fixed-point formats; no dependencies.
`default_nettype none
package obb_pkg;
    localparam int FIELD_W        = 48;
    localparam int COORD_BITS     = 16;
    localparam int AXIS_FRAC_BITS = 14;
    localparam int NUM_FIELDS     = 10;
    localparam int NUM_AXES       = 15;
endpackage
`default_nettype wire

### rtl/obb_axis.sv
// One candidate-axis separation test, three register stages.
// Uses obb_pkg for default widths.
`default_nettype none
module obb_axis #(
    parameter int COORD_BITS     = obb_pkg::COORD_BITS,
    parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS
) (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire logic signed [COORD_BITS:0]   i_d    [3],
    input  wire logic signed [2*COORD_BITS:0] i_l    [3],
    input  wire logic signed [COORD_BITS-1:0] i_ax   [6][3],
    input  wire logic [COORD_BITS-1:0]        i_half [6],
    output logic                        o_sep
);
    localparam int C    = COORD_BITS;
    localparam int DPW  = 3*C + 4;   // center offset dot axis
    localparam int PMW  = 3*C + 3;   // |box axis dot axis|
    localparam int HPW  = 4*C + 3;   // half size times projection
    localparam int SUMW = 4*C + 6;
    localparam int CMPW = 4*C + AXIS_FRAC_BITS + 6;

    logic signed [DPW-1:0] r_dp, n_dp;
    logic [PMW-1:0]        r_pm [6];
    logic [PMW-1:0]        n_pm [6];
    logic [C-1:0]          r_half [6];
    logic [DPW-1:0]        r_dist, n_dist;
    logic [HPW-1:0]        r_hp [6];
    logic [HPW-1:0]        n_hp [6];
    logic                  r_sep, n_sep;
    logic signed [PMW-1:0] s_dot [6];
    logic [SUMW-1:0]       s_sum;

    // stage 1: dot products
    always_comb begin
        n_dp = DPW'(i_d[0]) * DPW'(i_l[0]) + DPW'(i_d[1]) * DPW'(i_l[1])
             + DPW'(i_d[2]) * DPW'(i_l[2]);
        for (int i = 0; i < 6; i++) begin
            s_dot[i] = PMW'(i_ax[i][0]) * PMW'(i_l[0]) + PMW'(i_ax[i][1]) * PMW'(i_l[1])
                     + PMW'(i_ax[i][2]) * PMW'(i_l[2]);
            n_pm[i]  = s_dot[i][PMW-1] ? PMW'(-s_dot[i]) : PMW'(s_dot[i]);
        end
    end

    // stage 2: scale by half sizes, magnitude of offset
    always_comb begin
        n_dist = r_dp[DPW-1] ? DPW'(-r_dp) : DPW'(r_dp);
        for (int i = 0; i < 6; i++) begin
            n_hp[i] = HPW'(r_half[i]) * HPW'(r_pm[i]);
        end
    end

    // stage 3: radius sum and compare; offset carries the axis scale
    always_comb begin
        s_sum = '0;
        for (int i = 0; i < 6; i++) begin
            s_sum = s_sum + SUMW'(r_hp[i]);
        end
        n_sep = ({CMPW'(r_dist)} << AXIS_FRAC_BITS) > CMPW'(s_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp   <= n_dp;
            r_pm   <= n_pm;
            r_half <= i_half;
            r_dist <= n_dist;
            r_hp   <= n_hp;
            r_sep  <= n_sep;
        end
    end

    assign o_sep = r_sep;
endmodule
`default_nettype wire

### rtl/obb_obb_overlap_test.sv
// Top level of the oriented-box overlap test (separating axis test).
// Uses obb_pkg and instantiates obb_axis for each of the fifteen axes.
//
// Usage:
//   Input channel i_valid / o_ready carries one box pair per transaction:
//   center, three axes and half sizes for boxes A and B, each packed into a
//   48-bit field. Output channel o_valid / i_ready carries one bit per pair,
//   o_overlap, 1 when no face axis separates and, if no axis pair is equal, no cross axis does.
//   Pipeline: a result passes through six register stages (input register,
//   offset and cross-product stage, three axis-test stages, output register)
//   before o_valid rises.
//   Throughput: one pair per cycle while o_ready is high. All fifteen axes are
//   tested in parallel lanes, so no stage is shared and a pair enters every cycle.
//   Stall: the whole pipeline holds while a result waits on i_ready low;
//   o_ready drops only then, nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) clears all valid bits; the data registers
//   are not reset.
`default_nettype none
module obb_obb_overlap_test #(
    parameter int COORD_BITS     = obb_pkg::COORD_BITS,
    parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [47:0] i_box_a_center,
    input  wire  [47:0] i_box_a_right,
    input  wire  [47:0] i_box_a_up,
    input  wire  [47:0] i_box_a_forward,
    input  wire  [47:0] i_box_a_half,
    input  wire  [47:0] i_box_b_center,
    input  wire  [47:0] i_box_b_right,
    input  wire  [47:0] i_box_b_up,
    input  wire  [47:0] i_box_b_forward,
    input  wire  [47:0] i_box_b_half,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_overlap
);
    localparam int C  = COORD_BITS;
    localparam int FW = obb_pkg::FIELD_W;
    localparam int NF = obb_pkg::NUM_FIELDS;
    localparam int NA = obb_pkg::NUM_AXES;

    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // stage 0: input register
    logic [FW-1:0] r0_in [NF];
    logic          r0_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_in[0] <= i_box_a_center;
            r0_in[1] <= i_box_a_right;
            r0_in[2] <= i_box_a_up;
            r0_in[3] <= i_box_a_forward;
            r0_in[4] <= i_box_a_half;
            r0_in[5] <= i_box_b_center;
            r0_in[6] <= i_box_b_right;
            r0_in[7] <= i_box_b_up;
            r0_in[8] <= i_box_b_forward;
            r0_in[9] <= i_box_b_half;
        end
    end

    // stage 1: unpack, center offset, cross-product axes, equal-axis shortcut
    logic [C-1:0]          s_comp [NF][3];
    logic signed [C:0]     n1_d   [3];
    logic signed [2*C:0]   n1_l   [NA][3];
    logic signed [C-1:0]   n1_ax  [6][3];
    logic [C-1:0]          n1_half [6];
    logic                  n1_same;
    logic signed [C:0]     r1_d   [3];
    logic signed [2*C:0]   r1_l   [NA][3];
    logic signed [C-1:0]   r1_ax  [6][3];
    logic [C-1:0]          r1_half [6];
    logic                  r1_same, r1_v;

    always_comb begin
        for (int f = 0; f < NF; f++) begin
            for (int k = 0; k < 3; k++) begin
                // components beyond the field read as zero
                s_comp[f][k] = C'({{(3*C){1'b0}}, r0_in[f]} >> (k*C));
            end
        end
        for (int k = 0; k < 3; k++) begin
            n1_d[k] = (C+1)'($signed(s_comp[5][k])) - (C+1)'($signed(s_comp[0][k]));
            for (int i = 0; i < 3; i++) begin
                n1_ax[i][k]   = $signed(s_comp[1+i][k]);
                n1_ax[3+i][k] = $signed(s_comp[6+i][k]);
            end
            n1_half[k]   = s_comp[4][k];
            n1_half[3+k] = s_comp[9][k];
        end
        n1_same = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (s_comp[1+i][0] == s_comp[6+i][0] && s_comp[1+i][1] == s_comp[6+i][1]
                && s_comp[1+i][2] == s_comp[6+i][2]) begin
                n1_same = 1'b1;
            end
        end
        for (int a = 0; a < 6; a++) begin
            for (int k = 0; k < 3; k++) begin
                n1_l[a][k] = (2*C+1)'(n1_ax[a][k]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n1_l[6+3*i+j][0] = (2*C+1)'(n1_ax[i][1]) * (2*C+1)'(n1_ax[3+j][2])
                                 - (2*C+1)'(n1_ax[i][2]) * (2*C+1)'(n1_ax[3+j][1]);
                n1_l[6+3*i+j][1] = (2*C+1)'(n1_ax[i][2]) * (2*C+1)'(n1_ax[3+j][0])
                                 - (2*C+1)'(n1_ax[i][0]) * (2*C+1)'(n1_ax[3+j][2]);
                n1_l[6+3*i+j][2] = (2*C+1)'(n1_ax[i][0]) * (2*C+1)'(n1_ax[3+j][1])
                                 - (2*C+1)'(n1_ax[i][1]) * (2*C+1)'(n1_ax[3+j][0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d    <= n1_d;
            r1_l    <= n1_l;
            r1_ax   <= n1_ax;
            r1_half <= n1_half;
            r1_same <= n1_same;
        end
    end

    // stages 2..4: axis lanes
    logic [NA-1:0] w_sep;

    for (genvar g = 0; g < NA; g++) begin : g_axis
        obb_axis #(
            .COORD_BITS     (COORD_BITS),
            .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
        ) u_axis (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_d    (r1_d),
            .i_l    (r1_l[g]),
            .i_ax   (r1_ax),
            .i_half (r1_half),
            .o_sep  (w_sep[g])
        );
    end

    logic [2:0] r_same_d;
    logic [2:0] r_v_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_same_d <= {r_same_d[1:0], r1_same};
        end
    end

    // face axes first, then the equal-axis shortcut, then the cross axes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_overlap <= !(|w_sep[5:0]) && (r_same_d[2] || !(|w_sep[NA-1:6]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r_v_d   <= '0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r0_v    <= i_valid;
            r1_v    <= r0_v;
            r_v_d   <= {r_v_d[1:0], r1_v};
            o_valid <= r_v_d[2];
        end
    end
endmodule
`default_nettype wire

### dv/tb.sv
// Testbench for obb_obb_overlap_test: streams box pairs, predicts the overlap bit.
// Depends on obb_pkg and the obb_obb_overlap_test RTL; self-contained otherwise.
`timescale 1ns / 1ps
module tb;
    localparam int CB = obb_pkg::COORD_BITS;
    localparam int FB = obb_pkg::AXIS_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [15:0] ONE_AX = 16'sd1 <<< FB;

    typedef struct {
        logic [47:0] f [10];
    } t_pair;

    logic i_clk, i_rst_n, i_valid, i_ready;
    logic o_ready, o_valid, o_overlap;
    logic [47:0] fld [10];

    t_pair pending_pairs [$];
    bit    overlap_expected [$];
    int    mismatches, n_sent, n_recv, n_overlap, idle_cycles, tx_wait, rx_wait;
    bit    stim_done, timed_out;

    obb_obb_overlap_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_box_a_center(fld[0]), .i_box_a_right(fld[1]), .i_box_a_up(fld[2]),
        .i_box_a_forward(fld[3]), .i_box_a_half(fld[4]),
        .i_box_b_center(fld[5]), .i_box_b_right(fld[6]), .i_box_b_up(fld[7]),
        .i_box_b_forward(fld[8]), .i_box_b_half(fld[9]),
        .o_valid(o_valid), .i_ready(i_ready), .o_overlap(o_overlap)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint scomp(logic [47:0] v, int k);
        logic [CB-1:0] r;
        r = v[k*CB +: CB];
        return longint'($signed(r));
    endfunction

    // |D.L| > sum of projected half extents, exact in 192 bits
    function automatic bit axis_separates(longint d[3], longint l[3],
                                          longint ax[2][3][3], longint hf[2][3]);
        logic signed [191:0] d_proj, sum, p;
        d_proj = 0;
        sum = 0;
        for (int k = 0; k < 3; k++) d_proj += 192'(d[k]) * 192'(l[k]);
        if (d_proj < 0) d_proj = -d_proj;
        for (int b = 0; b < 2; b++)
            for (int i = 0; i < 3; i++) begin
                p = 0;
                for (int k = 0; k < 3; k++) p += 192'(ax[b][i][k]) * 192'(l[k]);
                if (p < 0) p = -p;
                sum += 192'(hf[b][i]) * p;
            end
        return d_proj > sum;
    endfunction

    function automatic bit boxes_overlap(t_pair t);
        longint ax[2][3][3], hf[2][3], d[3], l[3];
        for (int b = 0; b < 2; b++)
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) ax[b][i][k] = scomp(t.f[b*5+1+i], k);
                hf[b][k] = longint'(t.f[b*5+4][k*CB +: CB]);
            end
        for (int k = 0; k < 3; k++)
            d[k] = (scomp(t.f[5], k) - scomp(t.f[0], k)) * (longint'(1) << FB);
        for (int i = 0; i < 3; i++) begin
            if (axis_separates(d, ax[0][i], ax, hf)) return 0;
            if (axis_separates(d, ax[1][i], ax, hf)) return 0;
        end
        for (int i = 0; i < 3; i++)
            if (ax[0][i] == ax[1][i]) return 1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                l[0] = ax[0][i][1]*ax[1][j][2] - ax[0][i][2]*ax[1][j][1];
                l[1] = ax[0][i][2]*ax[1][j][0] - ax[0][i][0]*ax[1][j][2];
                l[2] = ax[0][i][0]*ax[1][j][1] - ax[0][i][1]*ax[1][j][0];
                if (axis_separates(d, l, ax, hf)) return 0;
            end
        return 1;
    endfunction

    function automatic logic [47:0] pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [15:0] small_coord();
        return 16'($signed($urandom_range(0, 4096)) - 2048);
    endfunction

    // a rotated frame: permuted/negated unit axes, sometimes jittered
    function automatic void rand_frame(ref logic [47:0] r, u, f);
        logic [15:0] c [3][3];
        int p;
        p = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                c[i][k] = (k == (i + p) % 3) ? ($urandom_range(0, 1) ? ONE_AX : -ONE_AX)
                                             : 16'd0;
                if ($urandom_range(0, 2) == 0)
                    c[i][k] += 16'($urandom_range(0, 12000)) - 16'(6000);
            end
        r = pack3(c[0][0], c[0][1], c[0][2]);
        u = pack3(c[1][0], c[1][1], c[1][2]);
        f = pack3(c[2][0], c[2][1], c[2][2]);
    endfunction

    task automatic add_pair(t_pair t);
        pending_pairs.push_back(t);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s at result %0d: got %0d want %0d", what, n_recv, got, want);
        mismatches++;
    endtask

    initial begin
        t_pair t;
        logic [47:0] ident [3];
        ident[0] = pack3(ONE_AX, '0, '0);
        ident[1] = pack3('0, ONE_AX, '0);
        ident[2] = pack3('0, '0, ONE_AX);
        // directed: touching, apart, equal-axis shortcut, zero axes, extremes
        for (int n = 0; n < 20; n++) begin
            for (int b = 0; b < 2; b++) begin
                t.f[b*5] = '0;
                for (int i = 0; i < 3; i++) t.f[b*5+1+i] = ident[i];
                t.f[b*5+4] = pack3(16'h0100, 16'h0100, 16'h0100);
            end
            case (n)
                1: t.f[5] = pack3(16'h0200, '0, '0);
                2: t.f[5] = pack3(16'h0201, '0, '0);
                3: t.f[5] = pack3('0, 16'hfdff, '0);
                4: begin t.f[5] = pack3(16'h0180, 16'h0180, '0);
                         t.f[6] = pack3(16'h2d41, 16'h2d41, '0);
                         t.f[7] = pack3(16'hd2bf, 16'h2d41, '0); end
                5: begin t.f[6] = '0; t.f[7] = '0; t.f[8] = '0;
                         t.f[5] = pack3(16'h0300, '0, '0); end
                6: begin for (int i = 0; i < 10; i++) t.f[i] = '1; end
                7: begin for (int i = 0; i < 10; i++) t.f[i] = '0; end
                8: begin t.f[0] = pack3(16'h8000, 16'h8000, 16'h8000);
                         t.f[5] = pack3(16'h7fff, 16'h7fff, 16'h7fff); end
                9: begin t.f[4] = '1; t.f[9] = '1;
                         t.f[5] = pack3(16'h7fff, 16'h8000, 16'h7fff); end
                10: begin for (int i = 1; i < 4; i++) t.f[i] = {3{16'h8000}};
                          t.f[5] = pack3(16'h0400, 16'h0400, 16'h0400); end
                11: begin for (int i = 6; i < 9; i++) t.f[i] = {3{16'h7fff}};
                          t.f[5] = pack3(16'h0400, 16'h0400, '0); end
                12: begin t.f[6] = pack3('0, '0, ONE_AX); t.f[8] = pack3(ONE_AX, '0, '0);
                          t.f[7] = pack3(16'h2d41, 16'h2d41, '0);
                          t.f[5] = pack3(16'h0170, 16'h0170, 16'h0170); end
                13: begin t.f[1] = pack3(16'h2d41, '0, 16'h2d41);
                          t.f[2] = pack3('0, ONE_AX, '0);
                          t.f[3] = pack3(16'hd2bf, '0, 16'h2d41);
                          t.f[6] = pack3(16'h2d41, 16'h2d41, '0);
                          t.f[7] = pack3(16'hd2bf, 16'h2d41, '0);
                          t.f[5] = pack3(16'h0190, 16'h0050, 16'h0190); end
                default: begin
                    for (int i = 0; i < 10; i++) t.f[i] = 48'({$urandom, $urandom});
                end
            endcase
            add_pair(t);
        end
        for (int n = 0; n < 450; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < 10; i++) t.f[i] = 48'({$urandom, $urandom});
            end else begin
                for (int b = 0; b < 2; b++) begin
                    t.f[b*5] = pack3(small_coord(), small_coord(), small_coord());
                    rand_frame(t.f[b*5+1], t.f[b*5+2], t.f[b*5+3]);
                    t.f[b*5+4] = pack3(16'($urandom_range(16, 1200)),
                                       16'($urandom_range(16, 1200)),
                                       16'($urandom_range(16, 1200)));
                end
                if ($urandom_range(0, 3) == 0) t.f[6] = t.f[1];
            end
            add_pair(t);
        end
        stim_done = 1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            tx_wait <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) n_sent <= n_sent + 1;
            if (tx_wait > 0 || pending_pairs.size() == 0) begin
                i_valid <= 0;
                if (tx_wait > 0) tx_wait <= tx_wait - 1;
            end else begin
                t_pair t;
                t = pending_pairs.pop_front();
                for (int i = 0; i < 10; i++) fld[i] <= t.f[i];
                overlap_expected.push_back(boxes_overlap(t));
                i_valid <= 1;
                tx_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            rx_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (overlap_expected.size() == 0) begin
                    report_mismatch("unexpected transaction", o_overlap, -1);
                end else begin
                    bit want;
                    want = overlap_expected.pop_front();
                    if (o_overlap !== want) report_mismatch("overlap", o_overlap, want);
                    n_overlap <= n_overlap + want;
                end
                n_recv <= n_recv + 1;
            end
            if (rx_wait > 0) begin
                i_ready <= 0;
                rx_wait <= rx_wait - 1;
            end else begin
                i_ready <= 1;
                if ($urandom_range(0, 7) == 0)
                    rx_wait <= (n_recv / 100) % 2 ? 0 : $urandom_range(0, 13);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
    end

    initial begin
        for (int i = 0; i < 10; i++) fld[i] = '0;
        i_valid = 0;
        i_ready = 0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        wait ((stim_done && pending_pairs.size() == 0 && !i_valid
               && overlap_expected.size() == 0) || timed_out);
        if (!timed_out) repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (timed_out) begin
            $display("watchdog expired with %0d results outstanding", overlap_expected.size());
            $display("** obb_obb_overlap_test: FAILED **");
        end else begin
            $display("checked %0d box pairs, %0d overlapping, %0d mismatches",
                     n_recv, n_overlap, mismatches);
            if (mismatches == 0 && overlap_expected.size() == 0)
                $display("** obb_obb_overlap_test: PASSED **");
            else
                $display("** obb_obb_overlap_test: FAILED **");
        end
        $finish;
    end
endmodule

### files.f
rtl/obb_pkg.sv
rtl/obb_axis.sv
rtl/obb_obb_overlap_test.sv
dv/tb.sv
